// ===== rtl/core/jpd_pkg.sv =====
// ----------------------------------------------------------------------------
// jpd_pkg: shared constants, types and helper functions
// Holds the table word codes, register indexes and saturation helpers of the
// joint PD command generator.
// ----------------------------------------------------------------------------
package jpd_pkg;

  localparam int DATA_W      = 32;
  localparam int FILT_BITS   = 16;
  localparam int ROW_BITS    = 4;
  localparam int READ_WORDS  = 15;
  localparam int DIVIDEND_W  = 64;
  localparam int DIVISOR_W   = 32;
  localparam int CFG_INDEX_W = 3;

  // Opcodes of an input transaction.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Word positions inside one joint's row of the state memory.
  localparam logic [ROW_BITS-1:0] W_Q0        = 4'd0;
  localparam logic [ROW_BITS-1:0] W_Q1        = 4'd1;
  localparam logic [ROW_BITS-1:0] W_DQ0       = 4'd2;
  localparam logic [ROW_BITS-1:0] W_DQ1       = 4'd3;
  localparam logic [ROW_BITS-1:0] W_KP0       = 4'd4;
  localparam logic [ROW_BITS-1:0] W_KP1       = 4'd5;
  localparam logic [ROW_BITS-1:0] W_KD0       = 4'd6;
  localparam logic [ROW_BITS-1:0] W_KD1       = 4'd7;
  localparam logic [ROW_BITS-1:0] W_TAU0      = 4'd8;
  localparam logic [ROW_BITS-1:0] W_TAU1      = 4'd9;
  localparam logic [ROW_BITS-1:0] W_DQ_LIMIT  = 4'd10;
  localparam logic [ROW_BITS-1:0] W_TAU_LIMIT = 4'd11;
  localparam logic [ROW_BITS-1:0] W_PARALLEL  = 4'd12;
  localparam logic [ROW_BITS-1:0] W_LAST_Q    = 4'd13;
  localparam logic [ROW_BITS-1:0] W_LAST_DQ   = 4'd14;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_TIME         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_FACTOR    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_MODE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_RECEIVED = 3'd4;

  typedef logic signed [DATA_W-1:0] sword_t;

  // Saturate a wide signed value to 32 signed bits.
  function automatic sword_t sat32(input logic signed [67:0] v);
    localparam logic signed [67:0] MAXV = 68'sd2147483647;
    localparam logic signed [67:0] MINV = -68'sd2147483648;
    if (v > MAXV) begin
      return 32'sh7fffffff;
    end else if (v < MINV) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Clamp to [-lim, lim]; a negative limit acts as zero.
  function automatic sword_t clamp_sym(input logic signed [33:0] v, input sword_t lim);
    logic signed [33:0] l;
    logic signed [33:0] nl;
    l  = lim[31] ? 34'sd0 : 34'(lim);
    nl = -l;
    if (v > l) begin
      return l[31:0];
    end else if (v < nl) begin
      return nl[31:0];
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/jpd_ram.sv =====
// ----------------------------------------------------------------------------
// jpd_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module jpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/jpd_divider.sv =====
// ----------------------------------------------------------------------------
// jpd_divider: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jpd_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [jpd_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [jpd_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [jpd_pkg::DIVIDEND_W-1:0]  quotient
);
  import jpd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   rem_shift;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // One restoring step.
  assign rem_shift = {rem, quotient[DIVIDEND_W-1]};
  assign diff      = rem_shift - {1'b0, dsr};
  assign ge        = rem_shift >= {1'b0, dsr};

  // Iteration counter, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count    <= CNT_W'(DIVIDEND_W);
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
      end else if (count != '0) begin
        rem      <= ge ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], ge};
        count    <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/joint_pd_command_generator.sv =====
// ----------------------------------------------------------------------------
// joint_pd_command_generator: per-joint PD motor command generator
// Table loads and per-joint position, velocity, torque and gain commands.
// ----------------------------------------------------------------------------
// A load transaction writes one table word and gives no result. A compute
// transaction reads the joint's row from the state memory, forms the phase
// (through the shared iterative divider when the time lies strictly inside
// the trajectory), runs ten multiply steps on the shared 33x33 multiplier, and
// in position mode with a nonzero gain divides twice more for the position
// bounds. It then writes back the last commands. All table words and the last
// commands live in one RAM with 16 words per joint; the last commands read as
// zero until a joint has been computed once.
module joint_pd_command_generator #(
  parameter int JOINTS    = 29,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [jpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [4:0]                        joint,
  input  logic [3:0]                        word_select,
  input  logic signed [31:0]                word_value,
  input  logic [31:0]                       now_time,
  input  logic signed [31:0]                measured_position,
  input  logic signed [31:0]                measured_velocity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [4:0]                        out_joint,
  output logic signed [31:0]                position_command,
  output logic signed [31:0]                velocity_command,
  output logic signed [31:0]                torque_command,
  output logic signed [31:0]                stiffness_command,
  output logic signed [31:0]                damping_command
);
  import jpd_pkg::*;

  localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int AJW    = (JW > 5) ? 5 : JW;
  localparam int ADDR_W = AJW + ROW_BITS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int VJ     = 1 << AJW;
  localparam int PH_W   = FRAC_BITS + 1;
  localparam int STEP_W = 4;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_READ  = 11'b00000000010,
    S_PHASE = 11'b00000000100,
    S_DIVP  = 11'b00000001000,
    S_CALC  = 11'b00000010000,
    S_DIVLO = 11'b00000100000,
    S_DIVHI = 11'b00001000000,
    S_CLAMP = 11'b00010000000,
    S_WRQ   = 11'b00100000000,
    S_WRDQ  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [16:0] filter_factor;
  logic        torque_mode;
  logic        command_received;

  // Latched compute transaction and row words.
  logic [4:0]       joint_r;
  logic [31:0]      now_r;
  sword_t           mq;
  sword_t           mdq;
  sword_t           words [READ_WORDS];
  logic [VJ-1:0]    lv_valid;
  logic [ROW_BITS-1:0] rd_cnt;
  logic [ROW_BITS-1:0] rd_idx;
  logic [STEP_W-1:0]   step;

  // Working registers.
  logic [PH_W-1:0]     phase;
  logic signed [65:0]  prod;
  logic signed [65:0]  acc;
  logic signed [63:0]  pp;
  sword_t q, dq, kp, kd, tau, taup, lo, hi;

  // Memory, multiplier and divider signals.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [31:0]         ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [31:0]         ram_rdata;
  logic signed [32:0]  ma;
  logic signed [32:0]  mb;
  logic                div_start;
  logic                div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic             accept;
  logic             joint_ok;
  logic [AJW-1:0]   jidx;
  logic             fm;
  logic             par_active;
  sword_t           tlim_eff;
  sword_t           eq, edq, vdq;
  logic signed [32:0] ph33, f33, fc33;
  logic signed [63:0] lim64, num_lo, num_hi;
  logic [31:0]      kp_mag;
  logic             phase_one, phase_zero;
  logic             out_free;

  // Rounded, saturated fixed-point product.
  function automatic sword_t rnd_q(input logic signed [65:0] p);
    logic signed [67:0] s;
    s = 68'(p) + (68'sd1 <<< (FRAC_BITS - 1));
    return sat32(s >>> FRAC_BITS);
  endfunction

  // Rounded low-pass blend of two products.
  function automatic sword_t blend_q(input logic signed [65:0] a, input logic signed [65:0] b);
    logic signed [67:0] s;
    s = 68'(a) + 68'(b) + (68'sd1 <<< (FILT_BITS - 1));
    return sat32(s >>> FILT_BITS);
  endfunction

  // Magnitude of a 64-bit signed value.
  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Signed quotient plus measured position, saturated.
  function automatic sword_t bound_q(input logic [63:0] m, input logic neg, input sword_t base);
    logic signed [67:0] qs;
    qs = $signed({4'b0, m});
    if (neg) begin
      qs = -qs;
    end
    return sat32(qs + 68'(base));
  endfunction

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign joint_ok   = ({27'b0, joint} < 32'(JOINTS));
  assign jidx       = joint_r[AJW-1:0];
  assign out_free   = !out_valid || !out_stall;

  // Operating modes and derived operands.
  assign fm         = (filter_factor != '0) && !filter_factor[16];
  assign par_active = !command_received && words[W_PARALLEL][0];
  assign tlim_eff   = words[W_TAU_LIMIT][31] ? 32'sd0 : words[W_TAU_LIMIT];
  assign eq         = sat32(68'(q) - 68'(mq));
  assign edq        = sat32(68'(dq) - 68'(mdq));
  assign vdq        = sat32(68'(mdq) - 68'(dq));
  assign ph33       = $signed(33'(phase));
  assign f33        = $signed(33'(filter_factor));
  assign fc33       = $signed(33'(17'h10000 - filter_factor));
  assign lim64      = $signed(64'(tlim_eff)) <<< FRAC_BITS;
  assign num_lo     = pp - lim64;
  assign num_hi     = pp + lim64;
  assign kp_mag     = kp[31] ? (~kp + 32'd1) : kp;
  assign phase_one  = (end_time <= start_time) || (now_r >= end_time);
  assign phase_zero = (now_r <= start_time);
  assign rd_idx     = rd_cnt - 1'b1;

  // Multiplier operand selection per step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0: begin
        ma = fm ? 33'(words[W_LAST_Q]) : 33'(words[W_Q1]);
        mb = fm ? f33 : ph33;
      end
      4'd1: begin
        ma = 33'(words[W_Q0]);
        mb = fc33;
      end
      4'd2: begin
        ma = fm ? 33'(words[W_LAST_DQ]) : 33'(words[W_DQ1]);
        mb = fm ? f33 : ph33;
      end
      4'd3: begin
        ma = 33'(words[W_DQ0]);
        mb = fc33;
      end
      4'd4: begin
        ma = 33'(words[W_KP1]);
        mb = ph33;
      end
      4'd5: begin
        ma = 33'(words[W_KD1]);
        mb = ph33;
      end
      4'd6: begin
        ma = (torque_mode || par_active) ? 33'(kp) : 33'(words[W_TAU1]);
        mb = (torque_mode || par_active) ? 33'(eq) : ph33;
      end
      4'd7: begin
        ma = 33'(kd);
        mb = 33'(edq);
      end
      4'd8: begin
        ma = 33'(kd);
        mb = 33'(vdq);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Memory write port: loads in idle, last commands on write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {joint[AJW-1:0], word_select};
    ram_wdata = word_value;
    unique case (state)
      S_IDLE: begin
        ram_we = accept && (opcode == OP_LOAD) && joint_ok && (word_select <= W_PARALLEL);
        if (word_select == W_PARALLEL) begin
          ram_wdata = {31'b0, word_value != 32'sd0};
        end
      end
      S_WRQ: begin
        ram_we    = 1'b1;
        ram_waddr = {jidx, W_LAST_Q};
        ram_wdata = q;
      end
      S_WRDQ: begin
        ram_we    = 1'b1;
        ram_waddr = {jidx, W_LAST_DQ};
        ram_wdata = dq;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = {jidx, rd_cnt};

  // Divider start and operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag64(num_hi);
    div_divisor  = kp_mag;
    unique case (state)
      S_PHASE: begin
        div_start    = !phase_one && !phase_zero;
        div_dividend = 64'(now_r - start_time) << FRAC_BITS;
        div_divisor  = end_time - start_time;
      end
      S_CALC: begin
        // The damping product is still in the multiplier register here.
        div_start    = (step == 4'd9) && !torque_mode && (kp != 32'sd0);
        div_dividend = mag64($signed(prod[63:0]) - lim64);
      end
      S_DIVLO: begin
        div_start = div_done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  jpd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  jpd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time       <= '0;
      end_time         <= '0;
      filter_factor    <= '0;
      torque_mode      <= 1'b0;
      command_received <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_TIME:       start_time       <= cfg_data;
        CFG_END_TIME:         end_time         <= cfg_data;
        CFG_FILTER_FACTOR:    filter_factor    <= cfg_data[16:0];
        CFG_TORQUE_MODE:      torque_mode      <= cfg_data[0];
        CFG_COMMAND_RECEIVED: command_received <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lv_valid  <= '0;
      rd_cnt    <= '0;
      step      <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_COMPUTE) && joint_ok) begin
            joint_r <= joint;
            now_r   <= now_time;
            mq      <= measured_position;
            mdq     <= measured_velocity;
            rd_cnt  <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          // Read the row; data arrives in the cycle after its address.
          if (rd_cnt != '0) begin
            if (((rd_idx == W_LAST_Q) || (rd_idx == W_LAST_DQ)) && !lv_valid[jidx]) begin
              words[rd_idx] <= 32'sd0;
            end else begin
              words[rd_idx] <= ram_rdata;
            end
          end
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == ROW_BITS'(READ_WORDS)) begin
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          step <= '0;
          if (phase_one) begin
            phase <= PH_W'(1) << FRAC_BITS;
            state <= S_CALC;
          end else if (phase_zero) begin
            phase <= '0;
            state <= S_CALC;
          end else begin
            state <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            phase <= div_quotient[PH_W-1:0];
            state <= S_CALC;
          end
        end
        S_CALC: begin
          // Each step consumes the product launched in the step before.
          step <= step + 1'b1;
          case (step)
            4'd1: begin
              if (fm) begin
                acc <= prod;
              end else begin
                q <= sat32(68'(words[W_Q0]) + 68'(rnd_q(prod)));
              end
            end
            4'd2: begin
              if (fm) begin
                q <= blend_q(acc, prod);
              end
            end
            4'd3: begin
              if (fm) begin
                acc <= prod;
              end else begin
                dq <= sat32(68'(words[W_DQ0]) + 68'(rnd_q(prod)));
              end
            end
            4'd4: begin
              if (fm) begin
                dq <= blend_q(acc, prod);
              end
            end
            4'd5: begin
              kp <= sat32(68'(words[W_KP0]) + 68'(rnd_q(prod)));
              dq <= clamp_sym(34'(dq), words[W_DQ_LIMIT]);
            end
            4'd6: begin
              kd <= sat32(68'(words[W_KD0]) + 68'(rnd_q(prod)));
            end
            4'd7: begin
              if (torque_mode) begin
                taup <= rnd_q(prod);
              end else if (par_active) begin
                tau <= clamp_sym(34'(rnd_q(prod)), tlim_eff);
                kp  <= 32'sd0;
              end else begin
                tau <= sat32(68'(words[W_TAU0]) + 68'(rnd_q(prod)));
              end
            end
            4'd8: begin
              if (torque_mode) begin
                tau <= clamp_sym(34'(taup) + 34'(rnd_q(prod)) + 34'(words[W_TAU0]),
                                 tlim_eff);
                kp  <= 32'sd0;
                kd  <= 32'sd0;
              end
            end
            4'd9: begin
              pp <= prod[63:0];
              if (!torque_mode && (kp != 32'sd0)) begin
                state <= S_DIVLO;
              end else begin
                state <= S_WRQ;
              end
            end
            default: ;
          endcase
        end
        S_DIVLO: begin
          if (div_done) begin
            lo    <= bound_q(div_quotient, num_lo[63] ^ kp[31], mq);
            state <= S_DIVHI;
          end
        end
        S_DIVHI: begin
          if (div_done) begin
            hi    <= bound_q(div_quotient, num_hi[63] ^ kp[31], mq);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // Order the bounds, then clamp the position.
          if (lo > hi) begin
            q <= (q < hi) ? hi : ((q > lo) ? lo : q);
          end else begin
            q <= (q < lo) ? lo : ((q > hi) ? hi : q);
          end
          state <= S_WRQ;
        end
        S_WRQ: begin
          state <= S_WRDQ;
        end
        S_WRDQ: begin
          lv_valid[jidx] <= 1'b1;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_joint         <= joint_r;
      position_command  <= q;
      velocity_command  <= dq;
      torque_command    <= tau;
      stiffness_command <= kp;
      damping_command   <= kd;
    end
  end

endmodule
